[sv/speech_text_sanitizer_assert.svh]
// Assertion macros shared by the sanitizer modules
`ifndef SPEECH_TEXT_SANITIZER_ASSERT_SVH
`define SPEECH_TEXT_SANITIZER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define STS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sts_pkg.sv]
// Shared types, constants and word tables of the speech text sanitizer
`timescale 1ns / 1ps
package sts_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int PEND_MAX          = 16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TERM  = 8'h00;

  localparam logic [7:0] LEAD_2   = 8'hC2;
  localparam logic [7:0] POUND_2  = 8'hA3;
  localparam logic [7:0] CENT_2   = 8'hA2;
  localparam logic [7:0] YEN_2    = 8'hA5;
  localparam logic [7:0] LEAD_3   = 8'hE2;
  localparam logic [7:0] EURO_2   = 8'h82;
  localparam logic [7:0] EURO_3   = 8'hAC;
  localparam logic [7:0] DASH_2   = 8'h80;
  localparam logic [7:0] EM_3     = 8'h94;
  localparam logic [7:0] EN_3     = 8'h93;
  localparam logic [7:0] LEN3_MIN = 8'hE0;
  localparam logic [7:0] LEN4_MIN = 8'hF0;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_WORD,
    ACT_PUSH,
    ACT_CLAUSE
  } act_e;

  typedef enum logic [1:0] {
    WORD_POUND,
    WORD_CENT,
    WORD_YEN,
    WORD_EURO
  } word_e;

  typedef enum logic [1:0] {
    SKIP_NONE,
    SKIP_PUNCT,
    SKIP_BLANK
  } skip_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH,
    ST_CHAR,
    ST_PUSH,
    ST_NEXT,
    ST_EFLUSH,
    ST_TERM
  } state_e;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic flush_step;
    logic char_step;
    logic push;
    logic capture;
    logic replay_load;
    logic term;
  } ctrl_cmd_t;

  typedef struct packed {
    act_e dec_act;
    act_e act;
    logic pend_nz;
    logic pend_full;
    logic flush_last;
    logic char_last;
    logic emitted;
    logic held_nz;
    logic replay_left;
    logic end_text;
    logic out_free;
  } dp_stat_t;

  // Letter p of a currency word
  function automatic logic [7:0] word_char(word_e w, logic [2:0] p);
    logic [7:0] c;
    c = CH_SPACE;
    case (w)
      WORD_POUND: begin
        case (p)
          3'd0: c = "p";
          3'd1: c = "o";
          3'd2: c = "u";
          3'd3: c = "n";
          default: c = "d";
        endcase
      end
      WORD_CENT: begin
        case (p)
          3'd0: c = "c";
          3'd1: c = "e";
          3'd2: c = "n";
          default: c = "t";
        endcase
      end
      WORD_YEN: begin
        case (p)
          3'd0: c = "y";
          3'd1: c = "e";
          default: c = "n";
        endcase
      end
      default: begin
        case (p)
          3'd0: c = "e";
          3'd1: c = "u";
          3'd2: c = "r";
          default: c = "o";
        endcase
      end
    endcase
    return c;
  endfunction

  // Index of the final letter of a currency word
  function automatic logic [2:0] word_last(word_e w);
    logic [2:0] n;
    case (w)
      WORD_POUND: n = 3'd4;
      WORD_CENT:  n = 3'd3;
      WORD_YEN:   n = 3'd2;
      default:    n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

[sv/sts_ctrl.sv]
// Sequencer of the speech text sanitizer
`timescale 1ns / 1ps
module sts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sts_pkg::dp_stat_t stat_i,
  output sts_pkg::ctrl_cmd_t cmd_o
);
  import sts_pkg::*;

  state_e state_q, state_d;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Advance through decode, flush, output and replay steps
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        case (stat_i.dec_act)
          ACT_EMIT, ACT_WORD: state_d = stat_i.pend_nz ? ST_FLUSH : ST_CHAR;
          ACT_PUSH:           state_d = stat_i.pend_full ? ST_FLUSH : ST_PUSH;
          ACT_CLAUSE:         state_d = stat_i.emitted ? ST_CHAR : ST_PUSH;
          default:            state_d = ST_NEXT;
        endcase
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush_step = 1'b1;
          if (stat_i.flush_last) begin
            state_d = (stat_i.act == ACT_PUSH) ? ST_PUSH : ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        if (stat_i.out_free) begin
          cmd_o.char_step = 1'b1;
          if (stat_i.char_last) begin
            state_d = (stat_i.act == ACT_CLAUSE) ? ST_PUSH : ST_NEXT;
          end
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_NEXT;
      end
      ST_NEXT: begin
        if (!stat_i.end_text) begin
          state_d = ST_IDLE;
        end else if (stat_i.replay_left) begin
          cmd_o.replay_load = 1'b1;
          state_d           = ST_DECODE;
        end else if (stat_i.held_nz) begin
          cmd_o.capture = 1'b1;
        end else if (stat_i.pend_nz) begin
          state_d = ST_EFLUSH;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_EFLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush_step = 1'b1;
          if (stat_i.flush_last) begin
            state_d = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (stat_i.out_free) begin
          cmd_o.term = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`include "speech_text_sanitizer_assert.svh"
  `STS_ASSERT_SAME(a_accept_idle, in_valid_i && !in_stall_o, cmd_o.load_in, "accept missed")
  `STS_ASSERT_NEXT(a_load_decode, cmd_o.load_in, state_q == ST_DECODE, "no decode after load")
  `STS_ASSERT_NEXT(a_term_idle, cmd_o.term, state_q == ST_IDLE, "no idle after terminator")

endmodule

[sv/sts_dp.sv]
// Datapath of the speech text sanitizer: byte decode, blank store, output word
`timescale 1ns / 1ps
module sts_dp #(
  parameter int PENDING_DEPTH = sts_pkg::PENDING_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  input  sts_pkg::ctrl_cmd_t cmd_i,
  output sts_pkg::dp_stat_t stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o
);
  import sts_pkg::*;

  localparam int DEPTH_EFF = (PENDING_DEPTH > PEND_MAX) ? PEND_MAX :
                             ((PENDING_DEPTH < 1) ? 1 : PENDING_DEPTH);
  localparam logic [4:0] DEPTH_EFF_W = 5'(DEPTH_EFF);

  // Control state
  logic [4:0]  pend_cnt_q;
  logic [15:0] pend_tab_q;
  logic        emitted_q;
  skip_e       skip_q;
  logic [1:0]  held_cnt_q;
  logic [2:0]  seq_len_q;
  logic        end_q;
  logic [1:0]  rcnt_q, rpos_q;
  logic [3:0]  fidx_q;
  logic [2:0]  wpos_q;
  logic        out_valid_q;

  // Payload
  logic [7:0]  cur_q;
  logic [7:0]  held_q [3];
  logic [7:0]  rb_q [2];
  act_e        act_q;
  logic [7:0]  char_q;
  word_e       word_q;
  logic        tab_q;
  logic [7:0]  out_byte_q;
  logic        last_q;

  // Decode results
  act_e        dec_act;
  logic [7:0]  dec_char;
  word_e       dec_word;
  logic        dec_tab;
  skip_e       dec_skip;
  logic [1:0]  dec_held_cnt;
  logic [2:0]  dec_seq_len;
  logic        dec_hold_wr;
  logic        dec_lead_wr;
  logic        b_blank, b_punct, b_pass, b_clause, b_alnum;
  logic        out_free, fire;
  logic [7:0]  fire_byte;
  logic        fire_last;
  logic        flush_last, char_last;

  // Classify the current byte
  always_comb begin
    b_blank  = (cur_q == CH_SPACE) || (cur_q == CH_TAB);
    b_punct  = (cur_q == ".") || (cur_q == ",") || (cur_q == "!") || (cur_q == "?") ||
               (cur_q == ";") || (cur_q == ":");
    b_alnum  = ((cur_q >= "A") && (cur_q <= "Z")) || ((cur_q >= "a") && (cur_q <= "z")) ||
               ((cur_q >= "0") && (cur_q <= "9"));
    b_pass   = b_alnum || (cur_q == CH_NL) || (cur_q == ".") || (cur_q == ",") ||
               (cur_q == "!") || (cur_q == "?") || (cur_q == "$") || (cur_q == "'");
    b_clause = (cur_q == ";") || (cur_q == ":") || (cur_q == "(") || (cur_q == ")") ||
               (cur_q == "[") || (cur_q == "]") || (cur_q == "{") || (cur_q == "}");
  end

  // Work out the action of the current byte and its effect on sequence state
  always_comb begin
    dec_act      = ACT_NONE;
    dec_char     = cur_q;
    dec_word     = WORD_POUND;
    dec_tab      = 1'b0;
    dec_skip     = skip_q;
    dec_held_cnt = held_cnt_q;
    dec_seq_len  = seq_len_q;
    dec_hold_wr  = 1'b0;
    dec_lead_wr  = 1'b0;
    if (held_cnt_q != 2'd0) begin
      if ((({1'b0, held_cnt_q} + 3'd1) >= seq_len_q) || (held_cnt_q == 2'd3)) begin
        dec_held_cnt = 2'd0;
        dec_act      = ACT_PUSH;
        if ((held_cnt_q == 2'd1) && (held_q[0] == LEAD_2)) begin
          if (cur_q == POUND_2) begin
            dec_act  = ACT_WORD;
            dec_word = WORD_POUND;
          end else if (cur_q == CENT_2) begin
            dec_act  = ACT_WORD;
            dec_word = WORD_CENT;
          end else if (cur_q == YEN_2) begin
            dec_act  = ACT_WORD;
            dec_word = WORD_YEN;
          end
        end else if ((held_cnt_q == 2'd2) && (held_q[0] == LEAD_3)) begin
          if ((held_q[1] == EURO_2) && (cur_q == EURO_3)) begin
            dec_act  = ACT_WORD;
            dec_word = WORD_EURO;
          end else if ((held_q[1] == DASH_2) && ((cur_q == EM_3) || (cur_q == EN_3))) begin
            dec_act = ACT_CLAUSE;
          end
        end
      end else begin
        dec_hold_wr  = 1'b1;
        dec_held_cnt = held_cnt_q + 2'd1;
      end
    end else if ((skip_q == SKIP_PUNCT) && b_punct) begin
      dec_act = ACT_NONE;
    end else if ((skip_q == SKIP_PUNCT) && b_blank) begin
      dec_skip = SKIP_BLANK;
    end else if ((skip_q == SKIP_BLANK) && b_blank) begin
      dec_act = ACT_NONE;
    end else begin
      dec_skip = SKIP_NONE;
      if (!cur_q[7]) begin
        if (b_pass) begin
          dec_act = ACT_EMIT;
        end else if (b_blank) begin
          dec_act = ACT_PUSH;
          dec_tab = (cur_q == CH_TAB);
        end else if (b_clause) begin
          dec_act = ACT_CLAUSE;
        end else begin
          dec_act = ACT_PUSH;
        end
      end else begin
        dec_lead_wr  = 1'b1;
        dec_held_cnt = 2'd1;
        dec_seq_len  = (cur_q < LEN3_MIN) ? 3'd2 : ((cur_q < LEN4_MIN) ? 3'd3 : 3'd4);
      end
    end
    if (dec_act == ACT_CLAUSE) begin
      dec_char = CH_COMMA;
      dec_skip = SKIP_PUNCT;
    end
  end

  // Select the outgoing byte
  assign out_free   = !out_valid_q || !out_stall_i;
  assign flush_last = (({1'b0, fidx_q} + 5'd1) == pend_cnt_q);
  assign char_last  = (act_q != ACT_WORD) || (wpos_q == word_last(word_q));
  assign fire       = cmd_i.flush_step || cmd_i.char_step || cmd_i.term;

  always_comb begin
    fire_last = 1'b0;
    if (cmd_i.flush_step) begin
      fire_byte = pend_tab_q[fidx_q] ? CH_TAB : CH_SPACE;
    end else if (cmd_i.char_step) begin
      fire_byte = (act_q == ACT_WORD) ? word_char(word_q, wpos_q) : char_q;
    end else begin
      fire_byte = CH_TERM;
      fire_last = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q  <= '0;
      pend_tab_q  <= '0;
      emitted_q   <= 1'b0;
      skip_q      <= SKIP_NONE;
      held_cnt_q  <= '0;
      seq_len_q   <= '0;
      end_q       <= 1'b0;
      rcnt_q      <= '0;
      rpos_q      <= '0;
      fidx_q      <= '0;
      wpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        end_q <= end_of_text_i;
      end
      if (cmd_i.decode) begin
        skip_q     <= dec_skip;
        held_cnt_q <= dec_held_cnt;
        seq_len_q  <= dec_seq_len;
        wpos_q     <= '0;
        if (dec_act == ACT_CLAUSE) begin
          pend_cnt_q <= '0;
          pend_tab_q <= '0;
        end
      end
      // Drain held blanks one per cycle while the output is free
      if (cmd_i.flush_step) begin
        emitted_q <= 1'b1;
        if (flush_last) begin
          fidx_q     <= '0;
          pend_cnt_q <= '0;
          pend_tab_q <= '0;
        end else begin
          fidx_q <= fidx_q + 4'd1;
        end
      end
      if (cmd_i.char_step) begin
        emitted_q <= 1'b1;
        wpos_q    <= wpos_q + 3'd1;
      end
      // Append one blank to the tail
      if (cmd_i.push) begin
        pend_tab_q[pend_cnt_q[3:0]] <= tab_q;
        pend_cnt_q                  <= pend_cnt_q + 5'd1;
      end
      // Take the bytes after the dropped lead byte for replay
      if (cmd_i.capture) begin
        rcnt_q     <= held_cnt_q - 2'd1;
        rpos_q     <= '0;
        held_cnt_q <= '0;
      end
      if (cmd_i.replay_load) begin
        rpos_q <= rpos_q + 2'd1;
      end
      if (cmd_i.term) begin
        pend_cnt_q <= '0;
        pend_tab_q <= '0;
        emitted_q  <= 1'b0;
        skip_q     <= SKIP_NONE;
        held_cnt_q <= '0;
        seq_len_q  <= '0;
        end_q      <= 1'b0;
        rcnt_q     <= '0;
        rpos_q     <= '0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q <= text_byte_i;
    end else if (cmd_i.replay_load) begin
      cur_q <= rb_q[rpos_q[0]];
    end
    if (cmd_i.decode) begin
      act_q  <= dec_act;
      char_q <= dec_char;
      word_q <= dec_word;
      tab_q  <= dec_tab;
      if (dec_lead_wr) begin
        held_q[0] <= cur_q;
      end
      if (dec_hold_wr) begin
        held_q[held_cnt_q] <= cur_q;
      end
    end else if (cmd_i.capture) begin
      tab_q <= 1'b0;
    end
    if (cmd_i.capture) begin
      rb_q[0] <= held_q[1];
      rb_q[1] <= held_q[2];
    end
    if (fire) begin
      out_byte_q <= fire_byte;
      last_q     <= fire_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  always_comb begin
    stat_o             = '0;
    stat_o.dec_act     = dec_act;
    stat_o.act         = act_q;
    stat_o.pend_nz     = (pend_cnt_q != 5'd0);
    stat_o.pend_full   = (pend_cnt_q >= DEPTH_EFF_W);
    stat_o.flush_last  = flush_last;
    stat_o.char_last   = char_last;
    stat_o.emitted     = emitted_q;
    stat_o.held_nz     = (held_cnt_q != 2'd0);
    stat_o.replay_left = (rpos_q != rcnt_q);
    stat_o.end_text    = end_q;
    stat_o.out_free    = out_free;
  end

`include "speech_text_sanitizer_assert.svh"
  `STS_ASSERT_SAME(a_pend_bound, 1'b1, pend_cnt_q <= DEPTH_EFF_W, "blank store overrun")
  `STS_ASSERT_NEXT(a_term_clear, cmd_i.term,
    (pend_cnt_q == 5'd0) && (held_cnt_q == 2'd0) && !emitted_q, "state not cleared")
  `STS_ASSERT_SAME(a_last_zero, out_valid_q && last_q, out_byte_q == CH_TERM,
    "last word not terminator")
  `STS_ASSERT_NEXT(a_push_nz, cmd_i.push, pend_cnt_q != 5'd0, "push lost")

endmodule

[sv/speech_text_sanitizer.sv]
// Top level of the speech text sanitizer
`timescale 1ns / 1ps
// Cleans a text for a speech engine, one input byte per word, and returns the
// cleaned bytes, ending each text with a zero byte flagged by last_o. A byte
// is decoded and handed off before the next is accepted, and each output byte
// it releases and each blank it stores takes its own step, since the single
// output register sends one byte per cycle while out_stall_i is low. At the end
// of a text, each dropped lead byte has the bytes after it replayed, then the
// held blanks and the terminator are sent.
// The input is stalled while a byte is being worked on, but the next byte is
// taken while the last result still waits at the output.
module speech_text_sanitizer #(
  parameter int PENDING_DEPTH = sts_pkg::PENDING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import sts_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sts_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

endmodule

[sim/tb.sv]
// Testbench for the speech text sanitizer: directed table plus random texts
`timescale 1ns / 1ps
module tb;
  import sts_pkg::*;

  typedef struct packed {
    logic [7:0] txt;
    logic       eot;
  } out_word_t;

  typedef struct {
    logic [7:0] txt;
    logic       eot;
    int         n_res;   // typed result count, -1 when left to the predictor
    logic [7:0] first;   // typed first result byte
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h41;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;

  out_word_t  clean_q[$];
  int         n_bad = 0;
  bit         calm = 1'b0;

  // Predictor state of one text
  logic [4:0] blank_cnt;
  logic [15:0] blank_tab;
  bit         said_any;
  skip_e      skip_st;
  logic [7:0] seq_buf[3];
  int         seq_have;
  int         seq_need;

  speech_text_sanitizer u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void put_clean(logic [7:0] b, logic l);
    out_word_t w;
    w.txt = b;
    w.eot = l;
    clean_q.push_back(w);
  endfunction

  function automatic void release_blanks();
    for (int i = 0; i < blank_cnt; i++) begin
      put_clean(blank_tab[i] ? CH_TAB : CH_SPACE, 1'b0);
      said_any = 1'b1;
    end
    blank_cnt = '0;
    blank_tab = '0;
  endfunction

  function automatic void say(logic [7:0] b);
    release_blanks();
    put_clean(b, 1'b0);
    said_any = 1'b1;
  endfunction

  function automatic void say_word(string s);
    for (int i = 0; i < s.len(); i++) say(s[i]);
  endfunction

  function automatic void hold_blank(logic [7:0] b);
    if (blank_cnt >= PENDING_DEPTH_DEF) release_blanks();
    if (b == CH_TAB) blank_tab[blank_cnt[3:0]] = 1'b1;
    blank_cnt++;
  endfunction

  function automatic void clause_break();
    blank_cnt = '0;
    blank_tab = '0;
    if (said_any) say(CH_COMMA);
    skip_st = SKIP_PUNCT;
    hold_blank(CH_SPACE);
  endfunction

  function automatic void close_seq(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2, int len);
    if (len == 2 && s0 == LEAD_2 && s1 == POUND_2) say_word("pound");
    else if (len == 2 && s0 == LEAD_2 && s1 == CENT_2) say_word("cent");
    else if (len == 2 && s0 == LEAD_2 && s1 == YEN_2) say_word("yen");
    else if (len == 3 && s0 == LEAD_3 && s1 == EURO_2 && s2 == EURO_3) say_word("euro");
    else if (len == 3 && s0 == LEAD_3 && s1 == DASH_2 && (s2 == EM_3 || s2 == EN_3))
      clause_break();
    else hold_blank(CH_SPACE);
  endfunction

  function automatic bit is_punct(logic [7:0] b);
    return b == "." || b == "," || b == "!" || b == "?";
  endfunction

  function automatic void clean_byte(logic [7:0] b);
    logic [7:0] s[4];
    int k;
    if (seq_have > 0) begin
      if (seq_have + 1 >= seq_need || seq_have >= 3) begin
        for (k = 0; k < seq_have && k < 3; k++) s[k] = seq_buf[k];
        s[k] = b;
        seq_have = 0;
        close_seq(s[0], s[1], s[2], k + 1);
      end else begin
        seq_buf[seq_have] = b;
        seq_have++;
      end
      return;
    end
    if (skip_st == SKIP_PUNCT) begin
      if (is_punct(b) || b == ";" || b == ":") return;
      if (b == CH_SPACE || b == CH_TAB) begin
        skip_st = SKIP_BLANK;
        return;
      end
    end else if (skip_st == SKIP_BLANK && (b == CH_SPACE || b == CH_TAB)) begin
      return;
    end
    skip_st = SKIP_NONE;
    if (b < 8'h80) begin
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
          b == CH_NL || is_punct(b) || b == "$" || b == "'") say(b);
      else if (b == CH_SPACE || b == CH_TAB) hold_blank(b);
      else if (b == ";" || b == ":" || b == "(" || b == ")" || b == "[" || b == "]" ||
               b == "{" || b == "}") clause_break();
      else hold_blank(CH_SPACE);
      return;
    end
    seq_need = (b < LEN3_MIN) ? 2 : ((b < LEN4_MIN) ? 3 : 4);
    seq_buf[0] = b;
    seq_have = 1;
  endfunction

  function automatic void clear_text();
    blank_cnt = '0;
    blank_tab = '0;
    said_any = 1'b0;
    skip_st = SKIP_NONE;
    seq_have = 0;
    seq_need = 0;
  endfunction

  // Predict all results of one accepted word
  function automatic void predict_clean(logic [7:0] b, logic eot);
    logic [7:0] rest[2];
    int n;
    clean_byte(b);
    if (eot) begin
      while (seq_have > 0) begin
        n = (seq_have - 1 > 2) ? 2 : seq_have - 1;
        for (int i = 0; i < n; i++) rest[i] = seq_buf[i + 1];
        seq_have = 0;
        for (int i = 0; i < n; i++) clean_byte(rest[i]);
      end
      release_blanks();
      put_clean(CH_TERM, 1'b1);
      clear_text();
    end
  endfunction

  // Drive one word, idling at random first, and predict it on acceptance
  task automatic send_byte(logic [7:0] b, logic eot, int n_res = -1,
                           logic [7:0] first = 8'h00);
    int n_prev;
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    n_prev = clean_q.size();
    predict_clean(b, eot);
    if (n_res >= 0 && (clean_q.size() - n_prev != n_res ||
                       (n_res > 0 && clean_q[n_prev].txt != first))) begin
      n_bad++;
      if (n_bad <= 10)
        $display("table row %h: expected %0d results starting %h, got %0d starting %h",
                 b, n_res, first, clean_q.size() - n_prev,
                 (clean_q.size() > n_prev) ? clean_q[n_prev].txt : 8'h00);
    end
  endtask

  // Check each output word against the oldest prediction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clean_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word %h last %b", out_byte_o, last_o);
      end else begin
        if (clean_q[0].txt !== out_byte_o || clean_q[0].eot !== last_o) begin
          n_bad++;
          if (n_bad <= 10)
            $display("expected %h/%b got %h/%b", clean_q[0].txt, clean_q[0].eot,
                     out_byte_o, last_o);
        end
        void'(clean_q.pop_front());
      end
    end
    out_stall_i <= !calm && rst_ni && ($urandom_range(99) < 38);
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'(8'h61 + $urandom_range(25));
    if (r < 45) return $urandom_range(1) ? CH_TAB : CH_SPACE;
    if (r < 55) return 8'(8'h30 + $urandom_range(9));
    if (r < 65) begin
      case ($urandom_range(7))
        0: return ";";
        1: return ":";
        2: return "(";
        3: return ")";
        4: return "[";
        5: return "]";
        6: return "{";
        default: return "}";
      endcase
    end
    if (r < 75) begin
      case ($urandom_range(5))
        0: return ".";
        1: return ",";
        2: return "!";
        3: return "?";
        4: return "$";
        default: return "'";
      endcase
    end
    return 8'($urandom_range(255, 1));
  endfunction

  initial begin
    row_t dir[$];
    int   sent;
    int   len;
    int   kind;
    int   calm_at;
    bit   calm_done;
    bit   paused;
    dir = '{
      '{"A", 1'b1, 2, "A"}, '{";", 1'b1, 2, CH_SPACE}, '{8'h01, 1'b1, 2, CH_SPACE},
      '{8'h7F, 1'b0, 0, 8'h00}, '{"z", 1'b1, 3, CH_SPACE},
      '{LEAD_2, 1'b0, 0, 8'h00}, '{POUND_2, 1'b0, 5, "p"},
      '{LEAD_2, 1'b0, 0, 8'h00}, '{CENT_2, 1'b0, 4, "c"},
      '{LEAD_2, 1'b0, 0, 8'h00}, '{YEN_2, 1'b0, 3, "y"},
      '{LEAD_3, 1'b0, 0, 8'h00}, '{EURO_2, 1'b0, 0, 8'h00}, '{EURO_3, 1'b0, 4, "e"},
      '{LEAD_3, 1'b0, -1, 8'h00}, '{DASH_2, 1'b0, -1, 8'h00}, '{EM_3, 1'b0, -1, 8'h00},
      '{"!", 1'b0, -1, 8'h00}, '{CH_TAB, 1'b0, -1, 8'h00}, '{LEAD_3, 1'b0, -1, 8'h00},
      '{DASH_2, 1'b0, -1, 8'h00}, '{EN_3, 1'b0, -1, 8'h00}, '{8'hFF, 1'b0, -1, 8'h00},
      '{LEAD_3, 1'b0, -1, 8'h00}, '{"Q", 1'b1, -1, 8'h00}
    };
    calm_at   = 0;
    calm_done = 1'b0;
    paused    = 1'b0;
    clear_text();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) send_byte(dir[i].txt, dir[i].eot, dir[i].n_res, dir[i].first);
    sent = 0;
    while (sent < 380) begin
      // run a long stretch with no idling on either side
      if (!calm && !calm_done && sent >= 120) begin
        calm    = 1'b1;
        calm_at = sent;
      end else if (calm && sent >= calm_at + 60) begin
        calm      = 1'b0;
        calm_done = 1'b1;
      end
      // hold the sender once until every result has drained
      if (!paused && sent >= 250) begin
        paused     = 1'b1;
        in_valid_i <= 1'b0;
        wait (clean_q.size() == 0);
        @(posedge clk_i);
      end
      len = $urandom_range(14, 1);
      for (int j = 0; j < len; j++) begin
        kind = $urandom_range(99);
        if (kind < 8) begin
          // blank run that can pass the hold depth
          repeat ($urandom_range(22, 12)) begin
            send_byte($urandom_range(1) ? CH_TAB : CH_SPACE, 1'b0);
            sent++;
          end
        end else if (kind < 20) begin
          send_byte($urandom_range(1) ? LEAD_3 : LEAD_2, 1'b0);
          case ($urandom_range(3))
            0: send_byte(8'(POUND_2 - $urandom_range(1)), 1'b0);
            1: send_byte(YEN_2, 1'b0);
            2: begin
              send_byte(EURO_2, 1'b0);
              send_byte(EURO_3, 1'b0);
            end
            default: begin
              send_byte(DASH_2, 1'b0);
              send_byte($urandom_range(1) ? EM_3 : EN_3, j == len - 1);
            end
          endcase
          sent += 3;
        end else begin
          send_byte(pick_byte(), j == len - 1);
          sent++;
        end
      end
      // close any text left open by a sequence branch
      send_byte(8'(8'h80 + $urandom_range(127) * (sent % 2)), 1'b1);
      sent++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    wait (clean_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (n_bad == 0 && clean_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sts_pkg.sv
sv/sts_ctrl.sv
sv/sts_dp.sv
sv/speech_text_sanitizer.sv
sim/tb.sv
